// ===== rtl/lfdr_pkg.sv =====
// Shared types and constants for the length-framed datagram receiver.
package lfdr_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_POLL = 2'd2;

    // Result event codes
    localparam logic [1:0] EV_TX   = 2'd0;
    localparam logic [1:0] EV_KV   = 2'd1;
    localparam logic [1:0] EV_READ = 2'd2;
    localparam logic [1:0] EV_POLL = 2'd3;

    // Reply operations held by the output sequencer
    localparam logic [1:0] OP_KV    = 2'd0;
    localparam logic [1:0] OP_IDENT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_POLL  = 2'd3;

    // Frame type bytes
    localparam logic [7:0] TYPE_POLL  = 8'h00;
    localparam logic [7:0] TYPE_KV    = 8'h01;
    localparam logic [7:0] TYPE_IDENT = 8'hFF;

    // Identify reply framing bytes
    localparam logic [7:0] ID_LEN  = 8'h04;
    localparam logic [7:0] ID_SYNC = 8'hFF;
    localparam logic [7:0] ID_TAIL = 8'hFB;

    // Identify reply byte positions
    localparam logic [2:0] ID_STEP_LEN  = 3'd0;
    localparam logic [2:0] ID_STEP_SYNC = 3'd1;
    localparam logic [2:0] ID_STEP_APP  = 3'd2;
    localparam logic [2:0] ID_STEP_DEV  = 3'd3;
    localparam logic [2:0] ID_STEP_TAIL = 3'd4;

    // Configuration register indexes
    localparam logic CFG_APP_TYPE  = 1'b0;
    localparam logic CFG_DEVICE_ID = 1'b1;

    // Smallest length that opens a frame, and overhead bytes (type, key, trailer) of a key/value frame
    localparam logic [7:0] MIN_FRAME_LEN = 8'd2;
    localparam logic [7:0] KV_OVERHEAD   = 8'd3;

    // One pending reply, handed from the receive logic to the sequencer
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_len;
        logic [7:0] val_len;
        logic       first;
        logic       poll_flag;
        logic       rd_ok;
    } reply_desc_t;

endpackage

// ===== rtl/length_framed_datagram_receiver_top.sv =====
// Length-framed datagram receiver: first result is out the cycle after input transfer.
// Throughput one input item per cycle while in_stall is low; an identify frame's last
// byte holds the output for five reply bytes (one per cycle unless out_stall) and so
// sets the worst-case rate. Frame bytes live in a single-port-write, registered-read
// memory of FRAME_DEPTH bytes. rst_n (async, active low) clears counters, flags, config
// and the output stage; frame memory contents are undefined until written.
module length_framed_datagram_receiver_top #(
    parameter int FRAME_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_res,
    output logic [7:0] byte_value,
    output logic [7:0] key_length,
    output logic [7:0] value_length,
    output logic       first_identify,
    output logic       last
);
    import lfdr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);

    logic [7:0]  app_type_reg;
    logic [7:0]  dev_id_reg;
    logic [7:0]  bytes_left_reg;
    logic [7:0]  bytes_left_next;
    logic [7:0]  frame_len_reg;
    logic [7:0]  frame_len_next;
    logic [7:0]  wr_pos_reg;
    logic [7:0]  wr_pos_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [7:0]  key_reg;
    logic [7:0]  key_next;
    logic        poll_reg;
    logic        poll_next;
    logic        ident_once_reg;
    logic        ident_once_next;

    logic        accept;
    logic        hold;
    logic        desc_valid;
    reply_desc_t desc;
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  rd_data_reg;
    logic [7:0]  frame_type;
    logic [7:0]  frame_key;
    logic [7:0]  len_m3;
    logic [7:0]  left_dec;

    logic [7:0] store_mem [FRAME_DEPTH];

    assign in_stall = hold;
    assign accept   = in_valid && !hold;
    assign left_dec = bytes_left_reg - 8'd1;
    assign len_m3   = frame_len_reg - KV_OVERHEAD;

    // Type and key come from the frame's first two bytes; the key may be the last byte
    assign frame_type = type_reg;
    assign frame_key  = (wr_pos_reg == 8'd1) ? rx_byte : key_reg;

    assign wr_en = accept && (kind == KIND_RX) && (bytes_left_reg != 8'd0)
                   && ({1'b0, wr_pos_reg} < 9'(FRAME_DEPTH));
    assign rd_en = accept && (kind == KIND_READ);

    // Receive state and reply decode
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        frame_len_next  = frame_len_reg;
        wr_pos_next     = wr_pos_reg;
        type_next       = type_reg;
        key_next        = key_reg;
        poll_next       = poll_reg;
        ident_once_next = ident_once_reg;
        desc_valid      = 1'b0;
        desc.op         = OP_KV;
        desc.key_len    = 8'd0;
        desc.val_len    = 8'd0;
        desc.first      = 1'b0;
        desc.poll_flag  = 1'b0;
        desc.rd_ok      = 1'b0;
        if (accept)
        begin
            unique case (kind)
                KIND_RX:
                begin
                    if (bytes_left_reg == 8'd0)
                    begin
                        if (rx_byte >= MIN_FRAME_LEN)
                        begin
                            bytes_left_next = rx_byte;
                            frame_len_next  = rx_byte;
                        end
                    end
                    else
                    begin
                        if (wr_pos_reg == 8'd0)
                        begin
                            type_next = rx_byte;
                        end
                        if (wr_pos_reg == 8'd1)
                        begin
                            key_next = rx_byte;
                        end
                        bytes_left_next = left_dec;
                        if (left_dec != 8'd0)
                        begin
                            wr_pos_next = wr_pos_reg + 8'd1;
                        end
                        else
                        begin
                            wr_pos_next = 8'd0;
                            // End of frame: check trailer, then act on type
                            if (rx_byte == ~frame_len_reg)
                            begin
                                priority if (frame_type == TYPE_POLL)
                                begin
                                    poll_next = 1'b1;
                                end
                                else if (frame_type == TYPE_KV)
                                begin
                                    if (frame_len_reg >= KV_OVERHEAD && frame_key <= len_m3)
                                    begin
                                        desc_valid   = 1'b1;
                                        desc.op      = OP_KV;
                                        desc.key_len = frame_key;
                                        desc.val_len = len_m3 - frame_key;
                                    end
                                end
                                else if (frame_type == TYPE_IDENT)
                                begin
                                    desc_valid      = 1'b1;
                                    desc.op         = OP_IDENT;
                                    desc.first      = !ident_once_reg;
                                    ident_once_next = 1'b1;
                                end
                                else
                                begin
                                    desc_valid = 1'b0;
                                end
                            end
                        end
                    end
                end
                KIND_READ:
                begin
                    desc_valid = 1'b1;
                    desc.op    = OP_READ;
                    desc.rd_ok = {1'b0, read_index} < 9'(FRAME_DEPTH);
                end
                KIND_POLL:
                begin
                    desc_valid     = 1'b1;
                    desc.op        = OP_POLL;
                    desc.poll_flag = poll_reg;
                    poll_next      = 1'b0;
                end
                default:
                begin
                    desc_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 8'd0;
            frame_len_reg  <= 8'd0;
            wr_pos_reg     <= 8'd0;
            poll_reg       <= 1'b0;
            ident_once_reg <= 1'b0;
            app_type_reg   <= 8'd0;
            dev_id_reg     <= 8'd0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            frame_len_reg  <= frame_len_next;
            wr_pos_reg     <= wr_pos_next;
            poll_reg       <= poll_next;
            ident_once_reg <= ident_once_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_APP_TYPE:  app_type_reg <= cfg_data;
                    CFG_DEVICE_ID: dev_id_reg   <= cfg_data;
                endcase
            end
        end
    end

    // Header byte capture, payload only
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        key_reg  <= key_next;
    end

    // Frame store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_pos_reg[AW-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[read_index[AW-1:0]];
        end
    end

    // Reply output sequencer
    lfdr_reply_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (accept && desc_valid),
        .desc           (desc),
        .rd_data        (rd_data_reg),
        .app_type       (app_type_reg),
        .dev_id         (dev_id_reg),
        .hold           (hold),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .byte_value     (byte_value),
        .key_length     (key_length),
        .value_length   (value_length),
        .first_identify (first_identify),
        .last           (last)
    );

    // Write position stays inside the frame being received
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg == 8'd0) |-> (wr_pos_reg == 8'd0))
        else $error("write position nonzero between frames");

    a_pos_len: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != 8'd0) |-> (wr_pos_reg + bytes_left_reg == frame_len_reg))
        else $error("write position and remaining count disagree");

    // Once identified, the flag never falls without reset
    a_ident_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ident_once_reg |=> ident_once_reg)
        else $error("identified flag cleared");

endmodule

// ===== rtl/lfdr_reply_seq.sv =====
// Output sequencer: holds one pending reply and emits its result transfers.
module lfdr_reply_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lfdr_pkg::reply_desc_t desc,
    input  logic [7:0]          rd_data,
    input  logic [7:0]          app_type,
    input  logic [7:0]          dev_id,
    output logic                hold,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          event_res,
    output logic [7:0]          byte_value,
    output logic [7:0]          key_length,
    output logic [7:0]          value_length,
    output logic                first_identify,
    output logic                last
);
    import lfdr_pkg::*;

    reply_desc_t d_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        xfer;
    logic        is_last;

    assign is_last = (d_reg.op != OP_IDENT) || (step_reg == ID_STEP_TAIL);
    assign xfer    = valid_reg && !out_stall;
    // Busy unless the final transfer of the held reply goes out this cycle
    assign hold    = valid_reg && !(xfer && is_last);

    // Sequencer control
    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (xfer)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = ID_STEP_LEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= ID_STEP_LEN;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    // Descriptor payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            d_reg <= desc;
        end
    end

    // Result fields
    always_comb
    begin
        event_res      = EV_TX;
        byte_value     = 8'd0;
        key_length     = 8'd0;
        value_length   = 8'd0;
        first_identify = 1'b0;
        unique case (d_reg.op)
            OP_KV:
            begin
                event_res    = EV_KV;
                key_length   = d_reg.key_len;
                value_length = d_reg.val_len;
            end
            OP_IDENT:
            begin
                event_res      = EV_TX;
                first_identify = d_reg.first;
                unique case (step_reg)
                    ID_STEP_LEN:  byte_value = ID_LEN;
                    ID_STEP_SYNC: byte_value = ID_SYNC;
                    ID_STEP_APP:  byte_value = app_type;
                    ID_STEP_DEV:  byte_value = dev_id;
                    default:      byte_value = ID_TAIL;
                endcase
            end
            OP_READ:
            begin
                event_res  = EV_READ;
                byte_value = d_reg.rd_ok ? rd_data : 8'd0;
            end
            default:
            begin
                event_res  = EV_POLL;
                byte_value = {7'd0, d_reg.poll_flag};
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign last      = is_last;

    // A new reply is only taken when the held one is done
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !hold)
        else $error("reply loaded while sequencer busy");

    // Only identify replies walk through steps
    a_step_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && d_reg.op != OP_IDENT) |-> (step_reg == ID_STEP_LEN))
        else $error("step counter moved on a single-result reply");

    // A non-final transfer advances to the next identify byte
    a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !is_last) |=> (valid_reg && step_reg == $past(step_reg) + 3'd1))
        else $error("identify reply did not advance");

endmodule
